// ----- sv/kvtl_pkg.sv -----
// ----------------------------------------------------------------------------
// kvtl_pkg
// Shared types, event and error codes, character constants and a word-end
// helper for the keyvalue text lexer and checker.
// ----------------------------------------------------------------------------
package kvtl_pkg;

    localparam int MAX_NESTING_DEF = 255;
    localparam int LINE_BITS_DEF   = 24;
    localparam int MAX_RESULTS     = 4;
    localparam int CNT_W           = 3;
    localparam int OUT_LINE_W      = 24;
    localparam logic [OUT_LINE_W-1:0] OUT_LINE_MAX = '1;

    localparam logic [2:0] EV_BYTE   = 3'd0;
    localparam logic [2:0] EV_STREND = 3'd1;
    localparam logic [2:0] EV_OPEN   = 3'd2;
    localparam logic [2:0] EV_CLOSE  = 3'd3;
    localparam logic [2:0] EV_DONE   = 3'd4;
    localparam logic [2:0] EV_ERROR  = 3'd5;

    localparam logic [2:0] ERR_QUOTE    = 3'd0;
    localparam logic [2:0] ERR_OPEN_END = 3'd1;
    localparam logic [2:0] ERR_STRAY    = 3'd2;
    localparam logic [2:0] ERR_NO_NAME  = 3'd3;
    localparam logic [2:0] ERR_NO_VALUE = 3'd4;
    localparam logic [2:0] ERR_DEPTH    = 3'd5;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        logic [2:0]            ev;
        logic                  role;
        logic [7:0]            ch;
        logic [OUT_LINE_W-1:0] line;
        logic [7:0]            nest;
        logic [2:0]            err;
        logic                  last;
    } res_t;

    typedef struct packed {
        logic [CNT_W-1:0]             count;
        res_t [MAX_RESULTS-1:0]       item;
    } res_bundle_t;

    function automatic logic is_word_end(input logic [7:0] c);
        logic r;
        r = 1'b0;
        case (c) inside
            CH_SP, CH_TAB, CH_CR, CH_LF, CH_LBRACE, CH_RBRACE, CH_QUOTE: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/kvtl_lexer.sv -----
// ----------------------------------------------------------------------------
// kvtl_lexer
// Lexer state and one-step tokenizer / grammar check: turns one byte or end
// marker into up to MAX_RESULTS events and updates the lexer state.
// ----------------------------------------------------------------------------
module kvtl_lexer #(
    parameter int MAX_NESTING = kvtl_pkg::MAX_NESTING_DEF,
    parameter int LINE_BITS   = kvtl_pkg::LINE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  logic [7:0]            text_byte,
    input  logic                  end_of_text,
    output kvtl_pkg::res_bundle_t results
);
    import kvtl_pkg::*;

    localparam int DEPTH_W = $clog2(MAX_NESTING + 1);
    localparam logic [DEPTH_W-1:0]   DEPTH_LIMIT = DEPTH_W'(MAX_NESTING);
    localparam logic [LINE_BITS-1:0] LINE_ONE    = LINE_BITS'(1);
    localparam logic [LINE_BITS-1:0] LINE_SAT    = '1;

    localparam logic [2:0] MODE_NORMAL  = 3'd0;
    localparam logic [2:0] MODE_SLASH   = 3'd1;
    localparam logic [2:0] MODE_COMMENT = 3'd2;
    localparam logic [2:0] MODE_QUOTED  = 3'd3;
    localparam logic [2:0] MODE_WORD    = 3'd4;

    logic [2:0]           mode_reg,   mode_next;
    logic                 av_reg,     av_next;
    logic [DEPTH_W-1:0]   depth_reg,  depth_next;
    logic [LINE_BITS-1:0] line_reg,   line_next;
    logic [LINE_BITS-1:0] tline_reg,  tline_next;
    logic                 role_reg,   role_next;
    logic                 failed_reg, failed_next;

    res_t [MAX_RESULTS-1:0] res_v;
    logic [CNT_W-1:0]       n_v;
    logic                   word_v;
    logic                   disp_v;

    function automatic logic [OUT_LINE_W-1:0] clamp_line(input logic [LINE_BITS-1:0] l);
        logic [31:0] w;
        w = 32'(l);
        if (w > 32'(OUT_LINE_MAX))
            return OUT_LINE_MAX;
        return w[OUT_LINE_W-1:0];
    endfunction

    function automatic res_t make_res(input logic [2:0] ev, input logic role,
                                      input logic [7:0] ch,
                                      input logic [LINE_BITS-1:0] l,
                                      input logic [DEPTH_W-1:0] d,
                                      input logic [2:0] err);
        res_t r;
        r.ev   = ev;
        r.role = role;
        r.ch   = ch;
        r.line = clamp_line(l);
        r.nest = 8'(d);
        r.err  = err;
        r.last = 1'b0;
        return r;
    endfunction

    always_comb
    begin
        mode_next   = mode_reg;
        av_next     = av_reg;
        depth_next  = depth_reg;
        line_next   = line_reg;
        tline_next  = tline_reg;
        role_next   = role_reg;
        failed_next = failed_reg;
        res_v       = '0;
        n_v         = '0;
        word_v      = 1'b0;
        disp_v      = 1'b0;
        if (step_en)
        begin
            if (failed_reg)
            begin
                if (end_of_text)
                begin
                    mode_next   = MODE_NORMAL;
                    av_next     = 1'b0;
                    depth_next  = '0;
                    line_next   = LINE_ONE;
                    tline_next  = LINE_ONE;
                    role_next   = 1'b0;
                    failed_next = 1'b0;
                end
            end
            else if (end_of_text)
            begin
                if (mode_reg == MODE_QUOTED)
                begin
                    res_v[n_v[1:0]] = make_res(EV_ERROR, 1'b0, 8'd0, tline_next,
                                               depth_next, ERR_QUOTE);
                    n_v = n_v + 3'd1;
                    failed_next = 1'b1;
                end
                else if (mode_reg == MODE_WORD || mode_reg == MODE_SLASH)
                begin
                    if (mode_reg == MODE_SLASH)
                    begin
                        res_v[n_v[1:0]] = make_res(EV_BYTE, role_next, CH_SLASH,
                                                   tline_next, depth_next, 3'd0);
                        n_v = n_v + 3'd1;
                    end
                    res_v[n_v[1:0]] = make_res(EV_STREND, role_next, 8'd0, tline_next,
                                               depth_next, 3'd0);
                    n_v = n_v + 3'd1;
                    av_next = ~role_next;
                end
                if (!failed_next)
                begin
                    if (av_next)
                        res_v[n_v[1:0]] = make_res(EV_ERROR, 1'b0, 8'd0, line_next,
                                                   depth_next, ERR_NO_VALUE);
                    else if (depth_next != '0)
                        res_v[n_v[1:0]] = make_res(EV_ERROR, 1'b0, 8'd0, line_next,
                                                   depth_next, ERR_OPEN_END);
                    else
                        res_v[n_v[1:0]] = make_res(EV_DONE, 1'b0, 8'd0, line_next,
                                                   depth_next, 3'd0);
                    n_v = n_v + 3'd1;
                end
                mode_next   = MODE_NORMAL;
                av_next     = 1'b0;
                depth_next  = '0;
                line_next   = LINE_ONE;
                tline_next  = LINE_ONE;
                role_next   = 1'b0;
                failed_next = 1'b0;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_QUOTED:
                    begin
                        if (text_byte == CH_QUOTE)
                        begin
                            res_v[n_v[1:0]] = make_res(EV_STREND, role_next, 8'd0,
                                                       tline_next, depth_next, 3'd0);
                            n_v = n_v + 3'd1;
                            av_next   = ~role_next;
                            mode_next = MODE_NORMAL;
                        end
                        else
                        begin
                            if (text_byte == CH_LF && line_next != LINE_SAT)
                                line_next = line_next + LINE_ONE;
                            res_v[n_v[1:0]] = make_res(EV_BYTE, role_next, text_byte,
                                                       tline_next, depth_next, 3'd0);
                            n_v = n_v + 3'd1;
                        end
                    end
                    MODE_COMMENT:
                    begin
                        if (text_byte == CH_LF)
                        begin
                            if (line_next != LINE_SAT)
                                line_next = line_next + LINE_ONE;
                            mode_next = MODE_NORMAL;
                        end
                    end
                    MODE_WORD:
                    begin
                        word_v = 1'b1;
                    end
                    MODE_SLASH:
                    begin
                        if (text_byte == CH_SLASH)
                            mode_next = MODE_COMMENT;
                        else
                        begin
                            res_v[n_v[1:0]] = make_res(EV_BYTE, role_next, CH_SLASH,
                                                       tline_next, depth_next, 3'd0);
                            n_v = n_v + 3'd1;
                            mode_next = MODE_WORD;
                            word_v    = 1'b1;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_NORMAL;
                        disp_v    = 1'b1;
                    end
                endcase

                if (word_v)
                begin
                    if (is_word_end(text_byte))
                    begin
                        res_v[n_v[1:0]] = make_res(EV_STREND, role_next, 8'd0,
                                                   tline_next, depth_next, 3'd0);
                        n_v = n_v + 3'd1;
                        av_next   = ~role_next;
                        mode_next = MODE_NORMAL;
                        disp_v    = 1'b1;
                    end
                    else
                    begin
                        res_v[n_v[1:0]] = make_res(EV_BYTE, role_next, text_byte,
                                                   tline_next, depth_next, 3'd0);
                        n_v = n_v + 3'd1;
                    end
                end

                if (disp_v)
                begin
                    if (text_byte == CH_LF)
                    begin
                        if (line_next != LINE_SAT)
                            line_next = line_next + LINE_ONE;
                    end
                    else if (text_byte == CH_SP || text_byte == CH_TAB || text_byte == CH_CR)
                    begin
                        mode_next = mode_next;
                    end
                    else if (text_byte == CH_SLASH)
                    begin
                        tline_next = line_next;
                        role_next  = av_next;
                        mode_next  = MODE_SLASH;
                    end
                    else if (text_byte == CH_LBRACE)
                    begin
                        if (!av_next)
                        begin
                            res_v[n_v[1:0]] = make_res(EV_ERROR, 1'b0, 8'd0, line_next,
                                                       depth_next, ERR_NO_NAME);
                            failed_next = 1'b1;
                        end
                        else if (depth_next >= DEPTH_LIMIT)
                        begin
                            res_v[n_v[1:0]] = make_res(EV_ERROR, 1'b0, 8'd0, line_next,
                                                       depth_next, ERR_DEPTH);
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            depth_next = depth_next + DEPTH_W'(1);
                            av_next    = 1'b0;
                            res_v[n_v[1:0]] = make_res(EV_OPEN, 1'b0, 8'd0, line_next,
                                                       depth_next, 3'd0);
                        end
                        n_v = n_v + 3'd1;
                    end
                    else if (text_byte == CH_RBRACE)
                    begin
                        if (av_next)
                        begin
                            res_v[n_v[1:0]] = make_res(EV_ERROR, 1'b0, 8'd0, line_next,
                                                       depth_next, ERR_NO_VALUE);
                            failed_next = 1'b1;
                        end
                        else if (depth_next == '0)
                        begin
                            res_v[n_v[1:0]] = make_res(EV_ERROR, 1'b0, 8'd0, line_next,
                                                       depth_next, ERR_STRAY);
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            depth_next = depth_next - DEPTH_W'(1);
                            res_v[n_v[1:0]] = make_res(EV_CLOSE, 1'b0, 8'd0, line_next,
                                                       depth_next, 3'd0);
                        end
                        n_v = n_v + 3'd1;
                    end
                    else if (text_byte == CH_QUOTE)
                    begin
                        tline_next = line_next;
                        role_next  = av_next;
                        mode_next  = MODE_QUOTED;
                    end
                    else
                    begin
                        tline_next = line_next;
                        role_next  = av_next;
                        mode_next  = MODE_WORD;
                        res_v[n_v[1:0]] = make_res(EV_BYTE, role_next, text_byte,
                                                   tline_next, depth_next, 3'd0);
                        n_v = n_v + 3'd1;
                    end
                end
            end
            if (n_v != '0)
                res_v[2'(n_v - 3'd1)].last = 1'b1;
        end
    end

    assign results.count = n_v;
    assign results.item  = res_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NORMAL;
            av_reg     <= 1'b0;
            depth_reg  <= '0;
            line_reg   <= LINE_ONE;
            tline_reg  <= LINE_ONE;
            role_reg   <= 1'b0;
            failed_reg <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            av_reg     <= av_next;
            depth_reg  <= depth_next;
            line_reg   <= line_next;
            tline_reg  <= tline_next;
            role_reg   <= role_next;
            failed_reg <= failed_next;
        end
    end

endmodule

// ----- sv/keyvalue_text_lexer_checker_top.sv -----
// ----------------------------------------------------------------------------
// keyvalue_text_lexer_checker_top
// Streaming keyvalues tokenizer and grammar checker: one text byte per
// transaction in, lexer / structure events out.
//
// Channel  Dir  Payload
// s_*      in   tdata[7:0] text_byte, tlast end_of_text
// m_*      out  tdata char_out/line_number/nest_level/error_code, tuser event/role,
//               tlast last_of_run
//
// One byte per cycle while each byte yields at most one event and m_tready is
// high; a byte is registered in the input stage, then its events in the result
// buffer. k events (k is at most 3) hold the buffer until all are taken, and the input stalls meanwhile.
// Async reset clears the lexer state and empties the input and result stages.
// A stalled output holds its transaction; the input stage takes the next byte
// in the cycle the last pending event is taken.
// ----------------------------------------------------------------------------
module keyvalue_text_lexer_checker_top #(
    parameter int MAX_NESTING = kvtl_pkg::MAX_NESTING_DEF,
    parameter int LINE_BITS   = kvtl_pkg::LINE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] char_out, [31:8] line_number,
                                   // [39:32] nest_level, [42:40] error_code
    output logic [3:0]  m_tuser,   // [2:0] event_res, [3] string_role
    output logic        m_tlast
);
    import kvtl_pkg::*;

    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_byte_reg;
    logic       in_eot_reg;
    logic       proc;

    res_bundle_t            lex_res;
    res_t [MAX_RESULTS-1:0] buf_reg;
    logic [CNT_W-1:0]       rem_reg, rem_next;
    logic [1:0]             idx_reg, idx_next;
    res_t                   cur;

    assign proc     = in_vld_reg && (rem_reg == '0 || (rem_reg == CNT_W'(1) && m_tready));
    assign s_tready = !in_vld_reg || proc;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (s_tvalid && s_tready)
            in_vld_next = 1'b1;
        else if (proc)
            in_vld_next = 1'b0;
    end

    kvtl_lexer #(
        .MAX_NESTING (MAX_NESTING),
        .LINE_BITS   (LINE_BITS)
    ) u_lexer (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (proc),
        .text_byte   (in_byte_reg),
        .end_of_text (in_eot_reg),
        .results     (lex_res)
    );

    always_comb
    begin
        rem_next = rem_reg;
        idx_next = idx_reg;
        if (proc)
        begin
            rem_next = lex_res.count;
            idx_next = '0;
        end
        else if (m_tvalid && m_tready)
        begin
            rem_next = rem_reg - CNT_W'(1);
            idx_next = idx_reg + 2'd1;
        end
    end

    assign cur      = buf_reg[idx_reg];
    assign m_tvalid = (rem_reg != '0);
    assign m_tdata  = {5'd0, cur.err, cur.nest, cur.line, cur.ch};
    assign m_tuser  = {cur.role, cur.ev};
    assign m_tlast  = cur.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            rem_reg    <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            rem_reg    <= rem_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_eot_reg  <= s_tlast;
        end
        if (proc)
            buf_reg <= lex_res.item;
    end

endmodule

// ----- sv/kvtl_checker.sv -----
// ----------------------------------------------------------------------------
// kvtl_checker
// Port-level checks on the event stream of the keyvalue text lexer.
// ----------------------------------------------------------------------------
module kvtl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);
    import kvtl_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output transaction changed while stalled");

    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2:0] != EV_BYTE |-> m_tdata[7:0] == 8'd0)
        else $error("char_out set on non-byte event");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2:0] != EV_ERROR |-> m_tdata[42:40] == 3'd0)
        else $error("error_code set on non-error event");

    a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[2:0] == EV_DONE || m_tuser[2:0] == EV_ERROR) |-> m_tlast)
        else $error("verdict event not last of run");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:8] != 24'd0)
        else $error("line_number is zero");

endmodule

bind keyvalue_text_lexer_checker_top kvtl_checker u_kvtl_checker (.*);
